// ===== design/pfe_pkg.sv =====
// Shared types, codes and letter helpers for the Playfair stream encryptor.
package pfe_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FILL,
        ST_LOOK_A,
        ST_LOOK_B,
        ST_LOOK_C,
        ST_KEY_B,
        ST_KEY_DONE,
        ST_OUT_A,
        ST_OUT_B
    } pfe_state_t;

    localparam logic [1:0] MODE_KEY    = 2'd0;
    localparam logic [1:0] MODE_FINISH = 2'd1;
    localparam logic [1:0] MODE_MSG    = 2'd2;
    localparam logic [1:0] MODE_END    = 2'd3;

    localparam logic [4:0] LETTER_I = 5'd8;
    localparam logic [4:0] LETTER_J = 5'd9;
    localparam logic [4:0] LETTER_X = 5'd23;

    localparam int SIDE    = 5;
    localparam int CELLS   = SIDE * SIDE;
    localparam int LETTERS = 26;

    localparam logic [6:0] ASCII_A = 7'h41;

    typedef struct packed {
        logic       ok;
        logic [4:0] idx;
    } letter_t;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
    } cell_rc_t;

    // Upper-cases an ASCII byte and maps it to a letter index with J folded into I.
    function automatic letter_t letter_of(input logic [7:0] ch);
        letter_t    res;
        logic [7:0] c;
        c = ch;
        if (c inside {[8'h61:8'h7A]})
        begin
            c = c - 8'd32;
        end
        res.ok  = (c inside {[8'h41:8'h5A]});
        res.idx = 5'(c - 8'h41);
        if (res.idx == LETTER_J)
        begin
            res.idx = LETTER_I;
        end
        return res;
    endfunction

    // Row and column of a square position 0..24.
    function automatic cell_rc_t rc_of(input logic [4:0] p);
        cell_rc_t   res;
        logic [4:0] base;
        if (p >= 5'(4 * SIDE))
        begin
            res.row = 3'd4;
        end
        else if (p >= 5'(3 * SIDE))
        begin
            res.row = 3'd3;
        end
        else if (p >= 5'(2 * SIDE))
        begin
            res.row = 3'd2;
        end
        else if (p >= 5'(SIDE))
        begin
            res.row = 3'd1;
        end
        else
        begin
            res.row = 3'd0;
        end
        base    = (5'(res.row) << 2) + 5'(res.row);
        res.col = 3'(p - base);
        return res;
    endfunction

    function automatic logic [4:0] cell_of(input logic [2:0] row, input logic [2:0] col);
        return (5'(row) << 2) + 5'(row) + 5'(col);
    endfunction

    // Step one row or column forward, wrapping around the square.
    function automatic logic [2:0] next_rc(input logic [2:0] x);
        return (x == 3'(SIDE - 1)) ? 3'd0 : x + 3'd1;
    endfunction

endpackage

// ===== design/playfair_stream_encryptor_core.sv =====
// Playfair 5x5 key square builder and message encryptor, one item at a time.

// A keyword byte (mode 0) needs only the decode state; a finish command (mode 1) also
// runs the fill, walking all 26 letters one per cycle through the key-square write
// port; a message byte or end of message needs only decode when no pair completes,
// and when one does it needs two reads of the letter-position memory, two reads of
// the key-square memory and two output beats, all through single memory ports under
// the sequencer. in_ready is high only while the sequencer is idle; the output
// register lets the next item be taken while the second letter of a pair still waits.
// The key square is built once after reset and cannot be rebuilt.
module playfair_stream_encryptor_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] mode,
    input  logic [7:0] char_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] cipher_letter,
    output logic       last_of_pair
);

    pfe_pkg::pfe_state_t state_reg, state_next;

    logic [pfe_pkg::LETTERS-1:0] used_reg, used_next;
    logic [4:0] count_reg, count_next;
    logic [4:0] fill_reg, fill_next;
    logic       pending_valid_reg, pending_valid_next;
    logic [4:0] pending_letter_reg, pending_letter_next;
    logic       prev_valid_reg, prev_valid_next;
    logic [4:0] prev_letter_reg, prev_letter_next;
    logic       out_valid_reg, out_valid_next;

    logic [1:0] mode_reg, mode_next;
    logic [7:0] char_reg, char_next;
    logic [4:0] a_reg, a_next;
    logic [4:0] b_reg, b_next;
    logic       found_reg, found_next;
    logic [4:0] p1_reg, p1_next;
    logic [4:0] o2_reg, o2_next;
    logic [4:0] k1_reg, k1_next;
    logic [4:0] k2_reg, k2_next;
    logic [6:0] cipher_reg, cipher_next;
    logic       last_reg, last_next;

    // Key square and its inverse map, letter to position.
    logic [4:0] key_mem [pfe_pkg::CELLS];
    logic [4:0] pos_mem [pfe_pkg::LETTERS];
    logic [4:0] key_rdata, pos_rdata;
    logic [4:0] key_raddr, pos_raddr;
    logic       mem_we;
    logic [4:0] wr_letter;

    pfe_pkg::letter_t  lt;
    pfe_pkg::cell_rc_t rc1, rc2;
    logic [4:0] p2;
    logic [4:0] o1;
    logic       out_free;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[count_reg] <= wr_letter;
            pos_mem[wr_letter] <= count_reg;
        end
        key_rdata <= key_mem[key_raddr];
        pos_rdata <= pos_mem[pos_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= pfe_pkg::ST_IDLE;
            used_reg          <= '0;
            count_reg         <= '0;
            fill_reg          <= '0;
            pending_valid_reg <= 1'b0;
            prev_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            used_reg          <= used_next;
            count_reg         <= count_next;
            fill_reg          <= fill_next;
            pending_valid_reg <= pending_valid_next;
            prev_valid_reg    <= prev_valid_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg           <= mode_next;
        char_reg           <= char_next;
        pending_letter_reg <= pending_letter_next;
        prev_letter_reg    <= prev_letter_next;
        a_reg              <= a_next;
        b_reg              <= b_next;
        found_reg          <= found_next;
        p1_reg             <= p1_next;
        o2_reg             <= o2_next;
        k1_reg             <= k1_next;
        k2_reg             <= k2_next;
        cipher_reg         <= cipher_next;
        last_reg           <= last_next;
    end

    always_comb
    begin
        state_next          = state_reg;
        used_next           = used_reg;
        count_next          = count_reg;
        fill_next           = fill_reg;
        pending_valid_next  = pending_valid_reg;
        pending_letter_next = pending_letter_reg;
        prev_valid_next     = prev_valid_reg;
        prev_letter_next    = prev_letter_reg;
        out_valid_next      = out_valid_reg;
        mode_next           = mode_reg;
        char_next           = char_reg;
        a_next              = a_reg;
        b_next              = b_reg;
        found_next          = found_reg;
        p1_next             = p1_reg;
        o2_next             = o2_reg;
        k1_next             = k1_reg;
        k2_next             = k2_reg;
        cipher_next         = cipher_reg;
        last_next           = last_reg;

        mem_we    = 1'b0;
        wr_letter = fill_reg;
        pos_raddr = a_reg;
        key_raddr = o2_reg;
        in_ready  = 1'b0;
        out_free  = !out_valid_reg || out_ready;

        lt  = pfe_pkg::letter_of(char_reg);
        p2  = used_reg[b_reg] ? pos_rdata : 5'd0;
        rc1 = pfe_pkg::rc_of(p1_reg);
        rc2 = pfe_pkg::rc_of(p2);
        if (rc1.row == rc2.row)
        begin
            o1 = pfe_pkg::cell_of(rc1.row, pfe_pkg::next_rc(rc1.col));
        end
        else if (rc1.col == rc2.col)
        begin
            o1 = pfe_pkg::cell_of(pfe_pkg::next_rc(rc1.row), rc1.col);
        end
        else
        begin
            o1 = pfe_pkg::cell_of(rc1.row, rc2.col);
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            pfe_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mode_next  = mode;
                    char_next  = char_in;
                    state_next = pfe_pkg::ST_DECODE;
                end
            end

            pfe_pkg::ST_DECODE:
            begin
                state_next = pfe_pkg::ST_IDLE;
                case (mode_reg)
                    pfe_pkg::MODE_KEY:
                    begin
                        wr_letter = lt.idx;
                        if (lt.ok && count_reg < 5'(pfe_pkg::CELLS) && !used_reg[lt.idx])
                        begin
                            mem_we               = 1'b1;
                            used_next[lt.idx]    = 1'b1;
                            count_next           = count_reg + 5'd1;
                        end
                    end

                    pfe_pkg::MODE_FINISH:
                    begin
                        fill_next  = '0;
                        state_next = pfe_pkg::ST_FILL;
                    end

                    pfe_pkg::MODE_MSG:
                    begin
                        if (lt.ok)
                        begin
                            prev_valid_next  = 1'b1;
                            prev_letter_next = lt.idx;
                            if (prev_valid_reg && prev_letter_reg == lt.idx)
                            begin
                                // A doubled letter gets an X in between; it either
                                // closes the open pair or opens a pair with the letter.
                                if (pending_valid_reg)
                                begin
                                    a_next              = pending_letter_reg;
                                    b_next              = pfe_pkg::LETTER_X;
                                    pending_letter_next = lt.idx;
                                end
                                else
                                begin
                                    a_next = pfe_pkg::LETTER_X;
                                    b_next = lt.idx;
                                end
                                state_next = pfe_pkg::ST_LOOK_A;
                            end
                            else if (pending_valid_reg)
                            begin
                                a_next             = pending_letter_reg;
                                b_next             = lt.idx;
                                pending_valid_next = 1'b0;
                                state_next         = pfe_pkg::ST_LOOK_A;
                            end
                            else
                            begin
                                pending_letter_next = lt.idx;
                                pending_valid_next  = 1'b1;
                            end
                        end
                    end

                    pfe_pkg::MODE_END:
                    begin
                        if (pending_valid_reg)
                        begin
                            a_next     = pending_letter_reg;
                            b_next     = pfe_pkg::LETTER_X;
                            state_next = pfe_pkg::ST_LOOK_A;
                        end
                        pending_valid_next  = 1'b0;
                        pending_letter_next = '0;
                        prev_valid_next     = 1'b0;
                        prev_letter_next    = '0;
                    end

                    default:
                    begin
                        state_next = pfe_pkg::ST_IDLE;
                    end
                endcase
            end

            pfe_pkg::ST_FILL:
            begin
                wr_letter = fill_reg;
                if (!used_reg[fill_reg] && fill_reg != pfe_pkg::LETTER_J &&
                    count_reg < 5'(pfe_pkg::CELLS))
                begin
                    mem_we              = 1'b1;
                    used_next[fill_reg] = 1'b1;
                    count_next          = count_reg + 5'd1;
                end
                if (fill_reg == 5'(pfe_pkg::LETTERS - 1))
                begin
                    state_next = pfe_pkg::ST_IDLE;
                end
                else
                begin
                    fill_next = fill_reg + 5'd1;
                end
            end

            pfe_pkg::ST_LOOK_A:
            begin
                pos_raddr  = a_reg;
                found_next = used_reg[a_reg];
                state_next = pfe_pkg::ST_LOOK_B;
            end

            pfe_pkg::ST_LOOK_B:
            begin
                // A letter not yet placed in the square is taken as the first cell.
                p1_next    = found_reg ? pos_rdata : 5'd0;
                pos_raddr  = b_reg;
                state_next = pfe_pkg::ST_LOOK_C;
            end

            pfe_pkg::ST_LOOK_C:
            begin
                key_raddr = o1;
                if (rc1.row == rc2.row)
                begin
                    o2_next = pfe_pkg::cell_of(rc2.row, pfe_pkg::next_rc(rc2.col));
                end
                else if (rc1.col == rc2.col)
                begin
                    o2_next = pfe_pkg::cell_of(pfe_pkg::next_rc(rc2.row), rc2.col);
                end
                else
                begin
                    o2_next = pfe_pkg::cell_of(rc2.row, rc1.col);
                end
                state_next = pfe_pkg::ST_KEY_B;
            end

            pfe_pkg::ST_KEY_B:
            begin
                k1_next    = key_rdata;
                key_raddr  = o2_reg;
                state_next = pfe_pkg::ST_KEY_DONE;
            end

            pfe_pkg::ST_KEY_DONE:
            begin
                k2_next    = key_rdata;
                state_next = pfe_pkg::ST_OUT_A;
            end

            pfe_pkg::ST_OUT_A:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    cipher_next    = pfe_pkg::ASCII_A + {2'b00, k1_reg};
                    last_next      = 1'b0;
                    state_next     = pfe_pkg::ST_OUT_B;
                end
            end

            pfe_pkg::ST_OUT_B:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    cipher_next    = pfe_pkg::ASCII_A + {2'b00, k2_reg};
                    last_next      = 1'b1;
                    state_next     = pfe_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pfe_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign cipher_letter = cipher_reg;
    assign last_of_pair  = last_reg;

endmodule

// ===== design/pfe_checker.sv =====
// Port-level assertions for the Playfair stream encryptor, bound to the top level.
module pfe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] cipher_letter,
    input logic       last_of_pair
);

    // A stalled output beat holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cipher_letter) &&
        $stable(last_of_pair))
    else $error("output beat changed while stalled");

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input taken on the cycle after an accepted beat");

    // Once the first letter of a pair is taken, the second follows at once.
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_pair |=> out_valid && last_of_pair)
    else $error("second letter of a pair did not follow");

    // No new item is taken while the first letter of a pair is still shown.
    a_no_input_mid_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_pair |-> !in_ready)
    else $error("input ready while a pair is half delivered");

endmodule

bind playfair_stream_encryptor_core pfe_checker u_pfe_checker (.*);
